[rtl/bicycle_model_derivative_top_assert.svh]
// Assertion macros for the bicycle-model derivative block.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef BICYCLE_MODEL_DERIVATIVE_TOP_ASSERT_SVH
`define BICYCLE_MODEL_DERIVATIVE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bmd_pkg.sv]
// Package for the bicycle-model derivative block: fixed-point constants,
// the CORDIC arctangent table, pipeline payload types and saturation.
// No dependencies.
`timescale 1ns / 1ps

package bmd_pkg;

  // Number format and angle constants.
  localparam int FRAC_BITS = 16;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint PI_F = (PI_Q30 + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
  localparam longint HALF_PI_F =
    (PI_Q30 + (longint'(1) << (30 - FRAC_BITS))) >>> (31 - FRAC_BITS);
  localparam longint TWO_PI_F = 2 * PI_F;

  // Heading reduction by reciprocal multiplication.
  localparam int HW = FRAC_BITS + 4;
  localparam int ZSH = 30 - FRAC_BITS;
  localparam longint MOD_MUL = (longint'(1) << 32) / TWO_PI_F;
  localparam longint MOD_OFF = (longint'(1) << 31) % TWO_PI_F;
  localparam logic [63:0] MOD_MUL_U = 64'(MOD_MUL);
  localparam logic [31:0] TWO_PI_U32 = 32'(TWO_PI_F);
  localparam logic [HW-1:0] TWO_PI_U = HW'(TWO_PI_F);
  localparam logic [HW-1:0] PI_U = HW'(PI_F);
  localparam logic [HW-1:0] MOD_OFF_U = HW'(MOD_OFF);
  localparam logic signed [HW:0] PI_S = (HW + 1)'(PI_F);
  localparam logic signed [HW:0] NEG_PI_S = (HW + 1)'(-PI_F);
  localparam logic signed [HW:0] HALF_PI_S = (HW + 1)'(HALF_PI_F);
  localparam logic signed [HW:0] NEG_HALF_PI_S = (HW + 1)'(-HALF_PI_F);
  localparam logic signed [HW:0] TWO_PI_S = (HW + 1)'(TWO_PI_F);
  localparam logic signed [33:0] STEER_MAX = 34'(HALF_PI_F - 1);
  localparam logic signed [33:0] STEER_MIN = 34'(1 - HALF_PI_F);

  // CORDIC.
  localparam int CORDIC_STAGES_DEF = 16;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // Tangent divider.
  localparam int DIV_BITS = 31;
  localparam int NW = 34 + FRAC_BITS;

  // Register reset and result extremes.
  localparam logic [30:0] IWB_RESET = 31'd43691;
  localparam logic signed [31:0] INT32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] INT32_MIN = 32'sh80000000;

  // Pass-through part of an item before the trigonometry is done.
  typedef struct packed {
    logic signed [31:0] sp;
    logic signed [31:0] ax;
    logic signed [31:0] sr;
    logic signed [32:0] d1;
    logic signed [32:0] d2;
    logic signed [17:0] st;
  } ctx_t;

  // Pass-through part of an item while the tangent is divided out.
  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] a;
    logic signed [31:0] ax;
    logic signed [31:0] sr;
    logic signed [32:0] d1;
    logic signed [32:0] d2;
  } tail_t;

  // Tangent result control.
  typedef struct packed {
    logic sat;
    logic neg;
  } tflag_t;

  // Rounded arctangent of 2^-i in Q2.30.
  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] v;
    unique case (i)
      0: v = 34'sd843314857;
      1: v = 34'sd497837829;
      2: v = 34'sd263043837;
      3: v = 34'sd133525159;
      4: v = 34'sd67021687;
      5: v = 34'sd33543516;
      6: v = 34'sd16775851;
      7: v = 34'sd8388437;
      8: v = 34'sd4194283;
      9: v = 34'sd2097149;
      10: v = 34'sd1048576;
      11: v = 34'sd524288;
      12: v = 34'sd262144;
      13: v = 34'sd131072;
      14: v = 34'sd65536;
      15: v = 34'sd32768;
      16: v = 34'sd16384;
      17: v = 34'sd8192;
      18: v = 34'sd4096;
      19: v = 34'sd2048;
      20: v = 34'sd1024;
      21: v = 34'sd512;
      22: v = 34'sd256;
      23: v = 34'sd128;
      24: v = 34'sd64;
      25: v = 34'sd32;
      26: v = 34'sd16;
      27: v = 34'sd8;
      28: v = 34'sd4;
      29: v = 34'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sh00_7fff_ffff) begin
      r = INT32_MAX;
    end else if (v < -68'sh00_8000_0000) begin
      r = INT32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/bmd_ifs.sv]
// Channel interfaces of the bicycle-model derivative block: input item,
// result item and configuration write. No dependencies.
`timescale 1ns / 1ps

interface bmd_item_if;
  logic valid;
  logic ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] heading;
  logic signed [31:0] speed;
  logic signed [17:0] steer_angle;
  logic signed [31:0] accel;
  logic signed [31:0] steer_rate;
  logic signed [31:0] goal_x;
  logic signed [31:0] goal_y;
  modport source (output valid, pos_x, pos_y, heading, speed, steer_angle, accel,
                  steer_rate, goal_x, goal_y, input ready);
  modport sink (input valid, pos_x, pos_y, heading, speed, steer_angle, accel,
                steer_rate, goal_x, goal_y, output ready);
endinterface

interface bmd_result_if;
  logic valid;
  logic ready;
  logic signed [31:0] rate_x;
  logic signed [31:0] rate_y;
  logic signed [31:0] rate_heading;
  logic signed [31:0] rate_speed;
  logic signed [31:0] rate_steer;
  logic approaching;
  modport source (output valid, rate_x, rate_y, rate_heading, rate_speed, rate_steer,
                  approaching, input ready);
  modport sink (input valid, rate_x, rate_y, rate_heading, rate_speed, rate_steer,
                approaching, output ready);
endinterface

interface bmd_cfg_if;
  logic valid;
  logic ready;
  logic [30:0] wdata;
  modport source (output valid, wdata, input ready);
  modport sink (input valid, wdata, output ready);
endinterface

[rtl/bmd_cordic.sv]
// Pipelined rotation-mode CORDIC, one micro-rotation per register stage.
// Depends on bmd_pkg for the gain and the arctangent table.
`timescale 1ns / 1ps

module bmd_cordic #(
  parameter int STAGES = bmd_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [33:0] z_i,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);
  import bmd_pkg::*;

  logic signed [33:0] x_q [STAGES];
  logic signed [33:0] y_q [STAGES];
  logic signed [33:0] z_q [STAGES-1];

  // One rotation per stage; the direction follows the sign of the residual angle.
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [33:0] x_in;
    logic signed [33:0] y_in;
    logic signed [33:0] z_in;

    if (i == 0) begin : g_first
      assign x_in = CORDIC_GAIN;
      assign y_in = '0;
      assign z_in = z_i;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_in[33]) begin
          x_q[i] <= x_in - (y_in >>> i);
          y_q[i] <= y_in + (x_in >>> i);
        end else begin
          x_q[i] <= x_in + (y_in >>> i);
          y_q[i] <= y_in - (x_in >>> i);
        end
      end
    end

    // The last stage has no use for the residual angle.
    if (i < STAGES - 1) begin : g_z
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (!z_in[33]) begin
            z_q[i] <= z_in - atan_q30(i);
          end else begin
            z_q[i] <= z_in + atan_q30(i);
          end
        end
      end
    end
  end

  assign cos_o = x_q[STAGES-1];
  assign sin_o = y_q[STAGES-1];

endmodule

[rtl/bicycle_model_derivative_top.sv]
// Kinematic bicycle-model derivative with goal-approach flag.
//
// Usage: an item on item_i carries the vehicle state, the control and a goal
// point; each item gives exactly one result item on result_o, in order. Both
// channels take an item at a rising edge with valid and ready high. cfg_i writes
// the inverse wheelbase (Q15.16) and is always ready; write it only while no
// item is in flight.
// Pipeline: the heading reduction, the CORDIC stages, one bit per stage of
// the 31-bit tangent divider and the product and output stages.
// Throughput: one item per cycle. The whole pipeline advances together while
// the output register is empty or being taken; when the receiver holds ready
// low with a result waiting, every stage holds and item_i.ready drops, so no
// item is lost or repeated.
// Reset clears all valid bits and loads the inverse wheelbase with its reset
// value; payload registers are not reset.
// Depends on bmd_pkg, bmd_ifs and bmd_cordic.
`timescale 1ns / 1ps

module bicycle_model_derivative_top #(
  parameter int CORDIC_STAGES = bmd_pkg::CORDIC_STAGES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bmd_item_if.sink  item_i,
  bmd_result_if.source result_o,
  bmd_cfg_if.sink   cfg_i
);
  import bmd_pkg::*;

  localparam int N = CORDIC_STAGES;
  localparam int DEPTH = 38 + N;

  logic             en;
  logic [DEPTH-1:0] v_q;
  logic [30:0]      iwb_q;

  // Configuration register.
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iwb_q <= IWB_RESET;
    end else if (cfg_i.valid) begin
      iwb_q <= cfg_i.wdata;
    end
  end

  // The pipeline moves as one whenever the output register is free.
  assign en = !v_q[DEPTH-1] || result_o.ready;
  assign item_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[DEPTH-2:0], item_i.valid};
    end
  end

  // Pass-through context, one register per stage up to the CORDIC output.
  ctx_t ctx_d;
  ctx_t ctx_q [N+4];

  always_comb begin
    ctx_d.sp = item_i.speed;
    ctx_d.ax = item_i.accel;
    ctx_d.sr = item_i.steer_rate;
    ctx_d.d1 = 33'(item_i.pos_x) - 33'(item_i.goal_x);
    ctx_d.d2 = 33'(item_i.pos_y) - 33'(item_i.goal_y);
    ctx_d.st = item_i.steer_angle;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx_q[0] <= ctx_d;
      for (int k = 1; k < N + 4; k++) begin
        ctx_q[k] <= ctx_q[k-1];
      end
    end
  end

  // Stage A: estimate of the heading turn count by reciprocal multiplication.
  logic [31:0] xu;
  logic [63:0] a_prod_q;
  logic [31:0] a_xu_q;

  assign xu = {~item_i.heading[31], item_i.heading[30:0]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_prod_q <= 64'(xu) * MOD_MUL_U;
      a_xu_q   <= xu;
    end
  end

  // Stage B: residue of the offset heading, below two turns.
  logic [31:0]   qe;
  logic [31:0]   rfull;
  logic [HW-1:0] b_r_q;

  assign qe    = a_prod_q[63:32];
  assign rfull = a_xu_q - 32'(qe * TWO_PI_U32);

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_r_q <= rfull[HW-1:0];
    end
  end

  // Stage C: final correction, then remove the offset to get heading mod two pi.
  logic [HW-1:0] r0;
  logic [HW-1:0] c_h_q;

  assign r0 = (b_r_q >= TWO_PI_U) ? b_r_q - TWO_PI_U : b_r_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_h_q <= (r0 >= MOD_OFF_U) ? r0 - MOD_OFF_U : r0 + TWO_PI_U - MOD_OFF_U;
    end
  end

  // Stage D: fold the heading into the right half plane and clamp the steering.
  logic signed [HW:0] hs;
  logic signed [HW:0] rr;
  logic signed [HW:0] rf;
  logic               ng;
  logic signed [33:0] st34;
  logic signed [33:0] stc;
  logic signed [33:0] d_zh_q;
  logic signed [33:0] d_zs_q;
  logic               neg_q [N+1];

  always_comb begin
    hs = signed'({1'b0, c_h_q});
    rr = (c_h_q >= PI_U) ? hs - TWO_PI_S : hs;
    ng = 1'b0;
    rf = rr;
    if (rr > HALF_PI_S) begin
      rf = PI_S - rr;
      ng = 1'b1;
    end else if (rr < NEG_HALF_PI_S) begin
      rf = NEG_PI_S - rr;
      ng = 1'b1;
    end
    st34 = 34'(ctx_q[2].st);
    stc  = st34;
    if (st34 > STEER_MAX) begin
      stc = STEER_MAX;
    end else if (st34 < STEER_MIN) begin
      stc = STEER_MIN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_zh_q   <= 34'(rf) <<< ZSH;
      d_zs_q   <= stc <<< ZSH;
      neg_q[0] <= ng;
      for (int k = 1; k < N + 1; k++) begin
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  // CORDIC lanes for the heading and the steering angle.
  logic signed [33:0] ch_raw;
  logic signed [33:0] sh;
  logic signed [33:0] cs;
  logic signed [33:0] ss;

  bmd_cordic #(.STAGES(N)) u_cordic_head (
    .clk_i (clk_i),
    .en_i  (en),
    .z_i   (d_zh_q),
    .cos_o (ch_raw),
    .sin_o (sh)
  );

  bmd_cordic #(.STAGES(N)) u_cordic_steer (
    .clk_i (clk_i),
    .en_i  (en),
    .z_i   (d_zs_q),
    .cos_o (cs),
    .sin_o (ss)
  );

  // Stage P1: velocity and heading-rate products, divider set-up for the tangent.
  ctx_t               pc;
  logic signed [33:0] ch;
  logic [33:0]        ss_abs;
  logic [NW-1:0]      n_d;
  logic [32:0]        dv_in;
  logic               ovf;
  logic signed [65:0] p_cx_q;
  logic signed [65:0] p_sy_q;
  logic signed [63:0] p_a_q;
  ctx_t               p_ctx_q;
  logic [NW-1:0]      p_n_q;
  logic [32:0]        p_d_q;
  tflag_t             p_f_q;

  always_comb begin
    pc     = ctx_q[N+3];
    ch     = neg_q[N] ? -ch_raw : ch_raw;
    ss_abs = ss[33] ? 34'(-ss) : 34'(ss);
    n_d    = NW'(ss_abs) << FRAC_BITS;
    dv_in  = cs[32:0];
    ovf    = 64'(n_d) >= (64'(dv_in) << 31);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_cx_q    <= 66'(pc.sp) * 66'(ch);
      p_sy_q    <= 66'(pc.sp) * 66'(sh);
      p_a_q     <= 64'(pc.sp) * 64'(signed'({1'b0, iwb_q}));
      p_ctx_q   <= pc;
      p_n_q     <= n_d;
      p_d_q     <= dv_in;
      p_f_q.sat <= cs[33] || (cs == '0) || ovf;
      p_f_q.neg <= ss[33];
    end
  end

  // Tangent divider: one quotient bit per stage, most significant first.
  tail_t         p_tail;
  logic [32:0]   dv_rem_q  [DIV_BITS];
  logic [30:0]   dv_quo_q  [DIV_BITS];
  logic [NW-1:0] dv_n_q    [DIV_BITS-1];
  logic [32:0]   dv_d_q    [DIV_BITS-1];
  tflag_t        dv_f_q    [DIV_BITS];
  tail_t         dv_tail_q [DIV_BITS];

  always_comb begin
    p_tail.rx = sat32(68'(p_cx_q >>> 30));
    p_tail.ry = sat32(68'(p_sy_q >>> 30));
    p_tail.a  = sat32(68'(p_a_q >>> FRAC_BITS));
    p_tail.ax = p_ctx_q.ax;
    p_tail.sr = p_ctx_q.sr;
    p_tail.d1 = p_ctx_q.d1;
    p_tail.d2 = p_ctx_q.d2;
  end

  for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
    logic [32:0]   rem_in;
    logic [30:0]   quo_in;
    logic [NW-1:0] n_in;
    logic [32:0]   d_in;
    tflag_t        f_in;
    tail_t         tail_in;
    logic [33:0]   t;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_in  = 33'(p_n_q >> DIV_BITS);
      assign quo_in  = '0;
      assign n_in    = p_n_q;
      assign d_in    = p_d_q;
      assign f_in    = p_f_q;
      assign tail_in = p_tail;
    end else begin : g_next
      assign rem_in  = dv_rem_q[j-1];
      assign quo_in  = dv_quo_q[j-1];
      assign n_in    = dv_n_q[j-1];
      assign d_in    = dv_d_q[j-1];
      assign f_in    = dv_f_q[j-1];
      assign tail_in = dv_tail_q[j-1];
    end

    assign t  = {rem_in, n_in[DIV_BITS-1-j]};
    assign ge = t >= 34'(d_in);

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_rem_q[j]  <= ge ? 33'(t - 34'(d_in)) : 33'(t);
        dv_quo_q[j]  <= quo_in | (31'(ge) << (DIV_BITS - 1 - j));
        dv_f_q[j]    <= f_in;
        dv_tail_q[j] <= tail_in;
      end
    end

    // The last stage no longer needs the dividend or the divisor.
    if (j < DIV_BITS - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_n_q[j] <= n_in;
          dv_d_q[j] <= d_in;
        end
      end
    end
  end

  // Stage E1: signed tangent, heading-rate product and approach products.
  tail_t              et;
  tflag_t             ef;
  logic [30:0]        eq;
  logic signed [31:0] tn;
  logic signed [63:0] e_rh_q;
  logic signed [64:0] e_ap1_q;
  logic signed [64:0] e_ap2_q;
  logic signed [31:0] e_rx_q;
  logic signed [31:0] e_ry_q;
  logic signed [31:0] e_ax_q;
  logic signed [31:0] e_sr_q;

  always_comb begin
    et = dv_tail_q[DIV_BITS-1];
    ef = dv_f_q[DIV_BITS-1];
    eq = dv_quo_q[DIV_BITS-1];
    if (ef.sat) begin
      tn = ef.neg ? INT32_MIN : INT32_MAX;
    end else begin
      tn = ef.neg ? -signed'({1'b0, eq}) : signed'({1'b0, eq});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_rh_q  <= 64'(et.a) * 64'(tn);
      e_ap1_q <= 65'(et.d1) * 65'(et.rx);
      e_ap2_q <= 65'(et.d2) * 65'(et.ry);
      e_rx_q  <= et.rx;
      e_ry_q  <= et.ry;
      e_ax_q  <= et.ax;
      e_sr_q  <= et.sr;
    end
  end

  // Output register: saturate the heading rate and take the sign of the dot product.
  logic signed [65:0] dot;
  logic signed [31:0] o_rx_q;
  logic signed [31:0] o_ry_q;
  logic signed [31:0] o_rh_q;
  logic signed [31:0] o_ax_q;
  logic signed [31:0] o_sr_q;
  logic               o_ap_q;

  assign dot = 66'(e_ap1_q) + 66'(e_ap2_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_rx_q <= e_rx_q;
      o_ry_q <= e_ry_q;
      o_rh_q <= sat32(68'(e_rh_q >>> FRAC_BITS));
      o_ax_q <= e_ax_q;
      o_sr_q <= e_sr_q;
      o_ap_q <= dot[65];
    end
  end

  assign result_o.valid        = v_q[DEPTH-1];
  assign result_o.rate_x       = o_rx_q;
  assign result_o.rate_y       = o_ry_q;
  assign result_o.rate_heading = o_rh_q;
  assign result_o.rate_speed   = o_ax_q;
  assign result_o.rate_steer   = o_sr_q;
  assign result_o.approaching  = o_ap_q;

endmodule

[rtl/bmd_checker.sv]
// Port-level checker for the bicycle-model derivative block, with its bind.
// Depends on bicycle_model_derivative_top_assert.svh and the top level.
`timescale 1ns / 1ps
`include "bicycle_model_derivative_top_assert.svh"

module bmd_port_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [31:0] rate_x_i,
  input logic signed [31:0] rate_y_i,
  input logic               approaching_i
);

  // A result that is not taken stays, with rate_x unchanged.
  `BMD_ASSERT_NEXT(a_stall_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(rate_x_i), "result dropped or changed while stalled")

  // With the output register free the block must take an item.
  `BMD_ASSERT_NOW(a_ready_when_empty, !out_valid_i, in_ready_i, "input stalled with an empty output")

  // A receiver that is ready never holds up the input.
  `BMD_ASSERT_NOW(a_ready_follows, out_ready_i, in_ready_i, "input stalled while the receiver is ready")

  // A vehicle at rest is never approaching the goal.
  `BMD_ASSERT_NOW(a_rest_not_approaching, out_valid_i && rate_x_i == 0 && rate_y_i == 0, !approaching_i, "approach flagged with zero velocity")

endmodule

bind bicycle_model_derivative_top bmd_port_checker u_bmd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (item_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .rate_x_i      (result_o.rate_x),
  .rate_y_i      (result_o.rate_y),
  .approaching_i (result_o.approaching)
);

[dv/bmd_checker.sv]
// Checker for the bicycle-model derivative block: watches the item, result and
// configuration channels, predicts each result and compares it.
// Depends on bmd_pkg and bmd_ifs.
`timescale 1ns / 1ps

module bmd_checker (
  input  logic clk_i,
  input  logic rst_ni,
  bmd_item_if.sink    item_mon,
  bmd_result_if.sink  res_mon,
  bmd_cfg_if.sink     cfg_mon,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);
  import bmd_pkg::*;

  typedef struct {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rh;
    logic signed [31:0] rs;
    logic signed [31:0] rt;
    logic               appr;
  } deriv_t;

  deriv_t expected_q[$];
  longint inv_wheel_base;
  int errors;

  // Arctangent of 2^-i in Q2.30, rounded.
  function automatic longint arctan_step(input int i);
    longint tbl[30] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                        33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                        524288, 262144, 131072, 65536, 32768, 16384, 8192, 4096,
                        2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
    return tbl[i];
  endfunction

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Rotation-mode CORDIC from the gain constant; arithmetic shifts throughout.
  task automatic rotate(input longint z_in, output longint c, output longint s);
    longint x, y, z, xs, ys;
    x = 652032874;
    y = 0;
    z = z_in;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= arctan_step(i);
      end else begin
        x += ys; y -= xs; z += arctan_step(i);
      end
    end
    c = x;
    s = y;
  endtask

  // Kinematic derivative of one vehicle state.
  task automatic predict_derivative(output deriv_t d);
    longint px, py, hd, sp, st, gx, gy;
    longint r, ch, sh, cs, ss, tn, a, hi, lo, d1, d2;
    bit flip;
    px = item_mon.pos_x; py = item_mon.pos_y; hd = item_mon.heading;
    sp = item_mon.speed; st = item_mon.steer_angle;
    gx = item_mon.goal_x; gy = item_mon.goal_y;
    flip = 0;
    // Heading reduced to within a quarter turn either side of zero.
    r = hd % TWO_PI_F;
    if (r < 0) r += TWO_PI_F;
    if (r >= PI_F) r -= TWO_PI_F;
    if (r > HALF_PI_F) begin
      r = PI_F - r; flip = 1;
    end else if (r < -HALF_PI_F) begin
      r = -PI_F - r; flip = 1;
    end
    rotate(r * 16384, ch, sh);
    if (flip) ch = -ch;
    d.rx = 32'(clip32((sp * ch) >>> 30));
    d.ry = 32'(clip32((sp * sh) >>> 30));
    // Steering clamp and tangent.
    if (st > HALF_PI_F - 1) st = HALF_PI_F - 1;
    if (st < 1 - HALF_PI_F) st = 1 - HALF_PI_F;
    rotate(st * 16384, cs, ss);
    if (cs > 0) tn = clip32((ss * 65536) / cs);
    else tn = (ss >= 0) ? 64'sd2147483647 : -64'sd2147483648;
    a = clip32((sp * inv_wheel_base) >>> 16);
    d.rh = 32'(clip32((a * tn) >>> 16));
    d.rs = item_mon.accel;
    d.rt = item_mon.steer_rate;
    // Exact sign of the offset dotted with the velocity.
    d1 = px - gx;
    d2 = py - gy;
    hi = d1 * (longint'(d.rx) >>> 16) + d2 * (longint'(d.ry) >>> 16);
    lo = d1 * longint'(d.rx[15:0]) + d2 * longint'(d.ry[15:0]);
    hi += lo >>> 16;
    d.appr = hi < 0;
  endtask

  task automatic compare_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  assign fail_count = errors;
  assign pending_count = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    deriv_t d, e;
    if (!rst_ni) begin
      inv_wheel_base = 43691;
      expected_q.delete();
      errors = 0;
      result_count = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) inv_wheel_base = cfg_mon.wdata;
      if (item_mon.valid && item_mon.ready) begin
        predict_derivative(d);
        expected_q.push_back(d);
      end
      if (res_mon.valid && res_mon.ready) begin
        result_count++;
        if (expected_q.size() == 0) begin
          $error("result item with no expectation waiting");
          errors++;
        end else begin
          e = expected_q.pop_front();
          compare_field("rate_x", e.rx, res_mon.rate_x);
          compare_field("rate_y", e.ry, res_mon.rate_y);
          compare_field("rate_heading", e.rh, res_mon.rate_heading);
          compare_field("rate_speed", e.rs, res_mon.rate_speed);
          compare_field("rate_steer", e.rt, res_mon.rate_steer);
          compare_field("approaching", e.appr, res_mon.approaching);
        end
      end
    end
  end
endmodule

[dv/tb_bicycle_model_derivative_top.sv]
// Testbench top for the bicycle-model derivative block: clock, reset, stimulus
// with random idling, wheelbase settings and the verdict.
// Depends on bmd_pkg, bmd_ifs, bmd_checker and the block.
`timescale 1ns / 1ps

module tb_bicycle_model_derivative_top;
  import bmd_pkg::*;

  localparam int LATENCY = 53;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 0;
  logic rst_ni = 0;
  int fail_count, pending_count, result_count;
  int cycle_count = 0;
  int send_idle_pct, recv_idle_pct;
  int items_sent = 0;

  bmd_item_if   item_ch ();
  bmd_result_if res_ch ();
  bmd_cfg_if    cfg_ch ();

  bicycle_model_derivative_top DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_ch.sink),
    .result_o (res_ch.source),
    .cfg_i    (cfg_ch.sink)
  );

  bmd_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_mon      (item_ch.sink),
    .res_mon       (res_ch.sink),
    .cfg_mon       (cfg_ch.sink),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .result_count  (result_count)
  );

  always #10 clk_i = ~clk_i;

  // Cycle limit guards against a hang.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver stalls at random.
  always @(negedge clk_i) begin
    if (!rst_ni) res_ch.ready <= 0;
    else res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [31:0] edge_value(input int k);
    case (k)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Present one item and hold it until accepted; valid stays high for a
  // following item and drops only when the sender idles.
  task automatic send_item(input logic [31:0] px, py, hd, sp, input logic [17:0] st,
                           input logic [31:0] ax, sr, gx, gy);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 0;
      @(negedge clk_i);
    end
    item_ch.valid <= 1;
    item_ch.pos_x <= px; item_ch.pos_y <= py; item_ch.heading <= hd;
    item_ch.speed <= sp; item_ch.steer_angle <= st; item_ch.accel <= ax;
    item_ch.steer_rate <= sr; item_ch.goal_x <= gx; item_ch.goal_y <= gy;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_random();
    logic [31:0] hd, sp;
    logic [17:0] st;
    // Mostly modest speeds and headings, sometimes full range.
    hd = ($urandom_range(3) == 0) ? $urandom : 32'($signed($urandom_range(0, 2000000)) - 1000000);
    sp = ($urandom_range(3) == 0) ? $urandom : 32'($signed($urandom_range(0, 4000000)) - 2000000);
    case ($urandom_range(3))
      0: st = 18'($urandom);
      1: st = $urandom_range(1) ? 18'sd102943 : -18'sd102943;
      default: st = 18'($signed($urandom_range(0, 205886)) - 102943);
    endcase
    send_item($urandom, $urandom, hd, sp, st, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic wait_drained();
    item_ch.valid <= 0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic write_wheelbase(input logic [30:0] v);
    cfg_ch.valid <= 1;
    cfg_ch.wdata <= v;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid <= 0;
  endtask

  initial begin
    logic [30:0] wheelbase_set[5] = '{31'd1, 31'h7fff_ffff, 31'd43691, 31'd0, 31'd200000};
    item_ch.valid = 0;
    item_ch.pos_x = 0; item_ch.pos_y = 0; item_ch.heading = 0; item_ch.speed = 0;
    item_ch.steer_angle = 0; item_ch.accel = 0; item_ch.steer_rate = 0;
    item_ch.goal_x = 0; item_ch.goal_y = 0;
    cfg_ch.valid = 0;
    cfg_ch.wdata = 0;
    send_idle_pct = 15;
    recv_idle_pct = 59;
    repeat (5) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed: field extremes, steering limits and beyond, headings at quarter turns.
    for (int k = 0; k < 5; k++)
      send_item(edge_value(k), edge_value(4 - k), edge_value(k), edge_value(k),
                (k % 2) ? 18'sh1ffff : 18'sh20000, edge_value(k), edge_value(4 - k),
                edge_value(4 - k), edge_value(k));
    send_item(0, 0, 32'(HALF_PI_F), 32'h10000, 18'sd102943, 1, 2, 32'h10000, 0);
    send_item(0, 0, 32'(PI_F), 32'h10000, -18'sd102943, 1, 2, 32'hfff0_0000, 0);
    send_item(0, 0, 32'(-HALF_PI_F), 32'h7fff_ffff, 18'sd102942, 3, 4, 0, 32'h100000);
    send_item(5, 5, 32'(TWO_PI_F), 32'h8000_0000, -18'sd102942, 3, 4, 5, 5);
    send_item(0, 0, 0, 32'h7fff_ffff, 18'sd0, 0, 0, 32'h8000_0000, 32'h8000_0000);
    send_item(1, 1, 32'(HALF_PI_F + 1), 32'h20000, 18'sd50000, 0, 0, 0, 0);

    // Random phases, each under a new wheelbase setting.
    for (int ph = 0; ph < 5; ph++) begin
      wait_drained();
      write_wheelbase(wheelbase_set[ph]);
      if (ph == 2) begin
        send_idle_pct = 59; recv_idle_pct = 15;
      end else if (ph == 4) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      for (int n = 0; n < 200; n++) begin
        if (n == 100 && ph == 1) wait_drained();
        send_random();
      end
    end

    wait_drained();
    $display("Sent %0d items over five wheelbase settings, checked %0d results.",
             items_sent, result_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
